>>> sv/positional_list_insert_delete_unit_defines.svh
// ----------------------------------------------------------------------------
// positional list insert/delete unit - assertion macros
// shared property wrappers, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// same-cycle implication
`define PLIDU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("plidu check failed");

// next-cycle implication
`define PLIDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("plidu check failed");

`endif

>>> sv/plidu_pkg.sv
// ----------------------------------------------------------------------------
// plidu_pkg
// shared constants, codes and sequencer states of the positional list unit
// ----------------------------------------------------------------------------
package plidu_pkg;

    localparam int DEPTH  = 32;
    localparam int AW     = $clog2(DEPTH);
    localparam int LEN_W  = 6;
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_GET_RD,
        S_GET_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_OUT
    } t_state;

endpackage

>>> sv/plidu_ram.sv
// ----------------------------------------------------------------------------
// plidu_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module plidu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/positional_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// ordered list of up to DEPTH signed 32-bit values, edited by position
// ----------------------------------------------------------------------------
// usage
//   slave channel: one request transaction per item; tuser carries the
//   operation (append, insert, delete, read), tdata the 1-based position and
//   the value. master channel: one result transaction per request; tuser
//   carries the status (ok, illegal position, list full), tdata the value
//   read or removed and the list length after the operation.
//   the elements live in one ram; a small sequencer moves them one entry at
//   a time (registered read, then write) through that single port pair.
//   errors go straight to the result; insert moves each entry from the tail
//   down to the slot, then writes the value; read and delete capture the
//   entry, and a delete then moves each later entry one place toward the head.
//   o_s_tready rises in the cycle right after the result is taken.
//   o_s_tready is low while an item is being worked on or its result waits.
//   a stalled sink simply holds the result in the output register.
//   reset (synchronous, active low) empties the list; the ram is not cleared
//   since only entries below the length are ever read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_unit
    import plidu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // position[5:0], value[37:6], zero pad[39:38]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // data_out[31:0], length[37:32], zero pad[39:38]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

`include "positional_list_insert_delete_unit_defines.svh"

    // sequencer and datapath registers
    t_state                    r_state,  n_state;
    logic [1:0]                r_op,     n_op;
    logic signed [DATA_W-1:0]  r_val,    n_val;
    logic [AW-1:0]             r_ptr,    n_ptr;     // ram entry being moved
    logic [AW-1:0]             r_tgt,    n_tgt;     // insert slot
    logic [LEN_W-1:0]          r_count,  n_count;
    logic [1:0]                r_status, n_status;
    logic signed [DATA_W-1:0]  r_data,   n_data;

    // ram port
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [DATA_W-1:0]         w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [DATA_W-1:0]         w_rdata;

    // request fields
    logic [LEN_W-1:0]          w_pos;
    logic [LEN_W-1:0]          w_pos_m1;
    logic signed [DATA_W-1:0]  w_value;

    // wide compares against the length
    logic [LEN_W:0]            w_count_x;
    logic [LEN_W:0]            w_ptr_x;
    logic [LEN_W:0]            w_tgt_p1;
    logic [LEN_W:0]            w_ptr_p1;
    logic [LEN_W:0]            w_ptr_p2;
    logic                      w_full;

    assign w_pos     = i_s_tdata[LEN_W-1:0];
    assign w_pos_m1  = w_pos - LEN_W'(1);
    assign w_value   = i_s_tdata[LEN_W +: DATA_W];

    assign w_count_x = {1'b0, r_count};
    assign w_ptr_x   = (LEN_W+1)'(r_ptr);
    assign w_tgt_p1  = (LEN_W+1)'(r_tgt) + (LEN_W+1)'(1);
    assign w_ptr_p1  = w_ptr_x + (LEN_W+1)'(1);
    assign w_ptr_p2  = w_ptr_x + (LEN_W+1)'(2);
    assign w_full    = (r_count >= LEN_W'(DEPTH));

    plidu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_val    = r_val;
        n_ptr    = r_ptr;
        n_tgt    = r_tgt;
        n_count  = r_count;
        n_status = r_status;
        n_data   = r_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = i_s_tuser;
                    n_val    = w_value;
                    n_status = ST_OK;
                    n_data   = '0;
                    unique case (i_s_tuser)
                        OP_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                n_ptr   = r_count[AW-1:0];
                                n_tgt   = r_count[AW-1:0];
                                n_state = S_INS_PUT;
                            end
                        end
                        OP_INSERT: begin
                            priority if (w_pos == '0 ||
                                         {1'b0, w_pos} > w_count_x + (LEN_W+1)'(1)) begin
                                n_status = ST_BADPOS;
                                n_state  = S_OUT;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                                n_state  = S_OUT;
                            end else begin
                                // tail entry moves first, walking toward the slot
                                n_ptr   = r_count[AW-1:0];
                                n_tgt   = w_pos_m1[AW-1:0];
                                n_state = (r_count >= w_pos) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        default: begin
                            // delete and read share the range check and first read
                            if (w_pos == '0 || w_pos > r_count) begin
                                n_status = ST_BADPOS;
                                n_state  = S_OUT;
                            end else begin
                                n_ptr   = w_pos_m1[AW-1:0];
                                n_state = S_GET_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                n_ptr   = r_ptr - AW'(1);
                n_state = (w_ptr_x > w_tgt_p1) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT: begin
                n_count = r_count + LEN_W'(1);
                n_state = S_OUT;
            end
            S_GET_RD: begin
                n_state = S_GET_CAP;
            end
            S_GET_CAP: begin
                n_data = w_rdata;
                priority if (r_op != OP_DELETE) begin
                    n_state = S_OUT;
                end else if (w_ptr_p1 < w_count_x) begin
                    n_state = S_DEL_RD;
                end else begin
                    n_count = r_count - LEN_W'(1);
                    n_state = S_OUT;
                end
            end
            S_DEL_RD: begin
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                n_ptr = r_ptr + AW'(1);
                if (w_ptr_p2 < w_count_x) begin
                    n_state = S_DEL_RD;
                end else begin
                    n_count = r_count - LEN_W'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ram control per sequencer step
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = w_rdata;
        w_raddr = r_ptr;
        unique case (r_state)
            S_INS_RD:  w_raddr = r_ptr - AW'(1);
            S_INS_WR:  w_we    = 1'b1;
            S_INS_PUT: begin
                w_we    = 1'b1;
                w_wdata = r_val;
            end
            S_DEL_RD:  w_raddr = r_ptr + AW'(1);
            S_DEL_WR:  w_we    = 1'b1;
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_val    <= n_val;
        r_ptr    <= n_ptr;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_data   <= n_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {2'b00, r_count, r_data};
    assign o_m_tuser  = r_status;

    // list never grows past its capacity
    `PLIDU_ASSERT_NOW(a_count_bound, 1'b1, r_count <= LEN_W'(DEPTH))
    // a full report only comes from a full list
    `PLIDU_ASSERT_NOW(a_full_means_full, o_m_tvalid && (o_m_tuser == ST_FULL),
        r_count == LEN_W'(DEPTH))
    // no request is taken while a result waits
    `PLIDU_ASSERT_NOW(a_one_in_flight, o_m_tvalid, !o_s_tready)
    // a delivered result frees the request side
    `PLIDU_ASSERT_NEXT(a_ready_after_out, o_m_tvalid && i_m_tready, o_s_tready)

endmodule

>>> dv/plidu_list_checker.sv
// ----------------------------------------------------------------------------
// plidu_list_checker
// watches both channels of the positional list unit, keeps a shadow copy of
// the list, predicts each result and compares it with what comes out
// ----------------------------------------------------------------------------
module plidu_list_checker
    import plidu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [39:0]      i_s_tdata,   // position[5:0], value[37:6], zero pad[39:38]
    input  logic [1:0]       i_s_tuser,   // operation[1:0]
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [39:0]      i_m_tdata,   // data_out[31:0], length[37:32], zero pad[39:38]
    input  logic [1:0]       i_m_tuser,   // status[1:0]
    output int unsigned      o_mismatch_count,
    output int unsigned      o_pending,
    output logic [LEN_W-1:0] o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  length;
    } t_list_result;

    logic [DATA_W-1:0] shadow_list [DEPTH];
    int                shadow_len;
    t_list_result      result_queue [$];
    int unsigned       mismatch_total;

    initial begin
        mismatch_total = 0;
        shadow_len     = 0;
        o_pending      = 0;
        o_list_len     = '0;
    end

    assign o_mismatch_count = mismatch_total;

    // applies one operation to the shadow list and returns its result
    function automatic t_list_result apply_list_op(input logic [1:0] op,
                                                   input logic [5:0] pos,
                                                   input logic [DATA_W-1:0] val);
        t_list_result r;
        int           p;
        int           k;
        p        = int'(pos);
        r.status = ST_OK;
        r.data   = '0;
        case (op)
            OP_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = val;
                    shadow_len++;
                end
            end
            OP_INSERT: begin
                // position check wins over the full check
                if (p < 1 || p > shadow_len + 1) begin
                    r.status = ST_BADPOS;
                end else if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = shadow_len; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                end
            end
            default: begin
                if (p < 1 || p > shadow_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = shadow_list[p-1];
                    if (op == OP_DELETE) begin
                        for (k = p; k < shadow_len; k++)
                            shadow_list[k-1] = shadow_list[k];
                        shadow_len--;
                    end
                end
            end
        endcase
        r.length = LEN_W'(shadow_len);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_list_result want,
                                 input t_list_result seen);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("[%0t] %s: exp st=%0d d=%0d len=%0d, got st=%0d d=%0d len=%0d",
                     $time, what, want.status, $signed(want.data), want.length,
                     seen.status, $signed(seen.data), seen.length);
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_list_result want;
        t_list_result seen;
        if (!i_rst_n) begin
            shadow_len = 0;
            result_queue.delete();
        end else begin
            // result side first: a result never belongs to a request taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                seen = '{status: i_m_tuser, data: i_m_tdata[31:0], length: i_m_tdata[37:32]};
                if (result_queue.size() == 0) begin
                    note_mismatch("result with no request outstanding", '0, seen);
                end else begin
                    want = result_queue.pop_front();
                    if (seen.status != want.status || seen.data != want.data ||
                        seen.length != want.length)
                        note_mismatch("result mismatch", want, seen);
                end
            end
            if (i_s_tvalid && i_s_tready)
                result_queue.push_back(apply_list_op(i_s_tuser, i_s_tdata[5:0],
                                                     i_s_tdata[37:6]));
        end
        o_pending  <= result_queue.size();
        o_list_len <= LEN_W'(shadow_len);
    end

endmodule

>>> dv/tb_positional_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete_unit
// drives request transactions into the positional list unit with random gaps,
// backpressures the result channel at random, and reports the verdict of the
// list checker that runs beside the block
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import plidu_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;   // far above the slowest legal run
    localparam int DRAIN_CYCLES = 100;       // longer than the worst insert latency
    localparam int HOLD_CYCLES  = 400;       // long sink stall
    localparam int BLOCK_COUNT  = 15;
    localparam int BLOCK_ITEMS  = 60;        // 15 x 60 = 900 random requests

    // operation mix of one random block
    typedef enum int {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } t_op_mix;

    // all block inputs start at known values
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        req_tvalid = 1'b0;
    logic        req_tready;
    logic [39:0] req_tdata  = '0;          // position[5:0], value[37:6], zero pad[39:38]
    logic [1:0]  req_tuser  = OP_APPEND;   // operation[1:0]
    logic        rsp_tvalid;
    logic        rsp_tready = 1'b0;
    logic [39:0] rsp_tdata;                // data_out[31:0], length[37:32], zero pad[39:38]
    logic [1:0]  rsp_tuser;                // status[1:0]

    int unsigned      chk_mismatches;
    int unsigned      chk_pending;
    logic [LEN_W-1:0] chk_list_len;

    // idling controls shared between the stimulus and the sink
    bit sender_idle   = 1'b1;
    bit sink_idle     = 1'b1;
    bit sink_hold_req = 1'b0;

    int unsigned cycle_count;

    positional_list_insert_delete_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (req_tvalid),
        .o_s_tready (req_tready),
        .i_s_tdata  (req_tdata),
        .i_s_tuser  (req_tuser),
        .o_m_tvalid (rsp_tvalid),
        .i_m_tready (rsp_tready),
        .o_m_tdata  (rsp_tdata),
        .o_m_tuser  (rsp_tuser)
    );

    plidu_list_checker u_list_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (req_tvalid),
        .i_s_tready       (req_tready),
        .i_s_tdata        (req_tdata),
        .i_s_tuser        (req_tuser),
        .i_m_tvalid       (rsp_tvalid),
        .i_m_tready       (rsp_tready),
        .i_m_tdata        (rsp_tdata),
        .i_m_tuser        (rsp_tuser),
        .o_mismatch_count (chk_mismatches),
        .o_pending        (chk_pending),
        .o_list_len       (chk_list_len)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one request transaction: optional random gap, then hold valid until taken.
    // valid is left high afterwards so back-to-back requests need no second write
    task automatic send_request(input logic [1:0] op, input logic [5:0] pos,
                                input logic [31:0] val);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_tvalid <= 1'b1;
        req_tuser  <= op;
        req_tdata  <= {2'b00, val, pos};
        @(posedge i_clk);
        while (!req_tready) @(posedge i_clk);
    endtask

    // random request shaped around the current list length so that most
    // positions are legal and the list regularly runs full and empty
    task automatic send_random_request(input t_op_mix mix);
        int          roll;
        int          hi;
        logic [1:0]  op;
        logic [5:0]  pos;
        logic [31:0] val;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                op = (roll < 45) ? OP_APPEND : (roll < 88) ? OP_INSERT :
                     (roll < 94) ? OP_DELETE : OP_READ;
            end
            MIX_SHRINK: begin
                op = (roll < 10) ? OP_APPEND : (roll < 25) ? OP_INSERT :
                     (roll < 75) ? OP_DELETE : OP_READ;
            end
            default: begin
                op = (roll < 25) ? OP_APPEND : (roll < 50) ? OP_INSERT :
                     (roll < 75) ? OP_DELETE : OP_READ;
            end
        endcase
        // highest legal position; insert may also land just past the tail
        hi = (op == OP_DELETE || op == OP_READ) ? int'(chk_list_len) : int'(chk_list_len) + 1;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            pos = 6'($urandom_range(1, (hi > 0) ? hi : 1));
        else if (roll < 90)
            pos = ($urandom_range(0, 1) != 0) ? 6'(hi + 1) : 6'd0;   // just out of range
        else
            pos = 6'($urandom_range(0, 63));
        case ($urandom_range(0, 19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = 32'h0000_0000;
            3:       val = 32'hffff_ffff;
            default: val = $urandom;
        endcase
        send_request(op, pos, val);
    endtask

    // result sink: random stall before each result transaction, one long
    // stall on request, and no stalls at all while sink_idle is off
    initial begin : result_sink
        int stall;
        forever begin
            if (sink_hold_req) begin
                stall         = HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end else begin
                stall = sink_idle ? $urandom_range(0, 14) : 0;
            end
            if (stall > 0) begin
                rsp_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_tready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_tvalid) @(posedge i_clk);
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int      blk;
        int      i;
        t_op_mix mix;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list errors, position zero and 63, value extremes,
        // insert at head, middle and tail, delete at head, middle and tail
        send_request(OP_READ,   6'd1,  32'h0000_0000);   // read on empty list
        send_request(OP_DELETE, 6'd1,  32'h0000_0000);   // delete on empty list
        send_request(OP_INSERT, 6'd0,  32'h0000_0005);   // position zero
        send_request(OP_INSERT, 6'd2,  32'h0000_0005);   // one past length+1
        send_request(OP_INSERT, 6'd1,  32'h8000_0000);   // first element
        send_request(OP_APPEND, 6'd63, 32'h7fff_ffff);   // append ignores position
        send_request(OP_INSERT, 6'd3,  32'hffff_ffff);   // insert at length+1
        send_request(OP_INSERT, 6'd2,  32'h0000_0000);   // middle
        send_request(OP_INSERT, 6'd1,  32'h1234_5678);   // head
        send_request(OP_READ,   6'd0,  32'hffff_ffff);   // position zero
        send_request(OP_READ,   6'd5,  32'h0000_0000);   // last element
        send_request(OP_READ,   6'd6,  32'h0000_0000);   // one past the tail
        send_request(OP_READ,   6'd63, 32'h0000_0000);   // all-ones position
        send_request(OP_DELETE, 6'd1,  32'h0000_0000);   // head
        send_request(OP_DELETE, 6'd4,  32'h0000_0000);   // tail
        send_request(OP_DELETE, 6'd2,  32'h0000_0000);   // middle
        send_request(OP_DELETE, 6'd3,  32'h0000_0000);   // one past the tail
        send_request(OP_INSERT, 6'd63, 32'haaaa_aaaa);   // far out of range
        send_request(OP_APPEND, 6'd0,  32'h5555_5555);
        send_request(OP_READ,   6'd3,  32'h0000_0000);
        send_request(OP_DELETE, 6'd1,  32'h0000_0000);
        send_request(OP_DELETE, 6'd1,  32'h0000_0000);
        send_request(OP_DELETE, 6'd1,  32'h0000_0000);   // back to empty

        // random blocks cycling grow / even / shrink so the list fills up,
        // hits the full cases, and drains again; idling changes per block
        for (blk = 0; blk < BLOCK_COUNT; blk++) begin
            mix         = (blk % 3 == 0) ? MIX_GROW : (blk % 3 == 1) ? MIX_EVEN : MIX_SHRINK;
            sender_idle = (blk % 4 != 1);
            sink_idle   = (blk % 5 != 2);
            // long sink stall while requests keep coming: the block backs up
            if (blk == 3)
                sink_hold_req = 1'b1;
            for (i = 0; i < BLOCK_ITEMS; i++)
                send_random_request(mix);
            // sender pause until every result transaction is back, once the
            // pending count includes the last request
            if (blk == 7) begin
                req_tvalid <= 1'b0;
                @(posedge i_clk);
                while (chk_pending != 0) @(posedge i_clk);
            end
        end

        req_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chk_mismatches == 0 && chk_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
